[rtl/cnmd_pkg.sv]
package cnmd_pkg;

	localparam int CT_W    = 17;
	localparam int BOUND_W = 16;
	localparam int DENS_W  = 16;
	localparam int MED_W   = 3;
	localparam int BAND_W  = 48;
	localparam int IDX_W   = 3;

	// Divider operand widths: dividend is 2*|num| + |width|, divisor 2*|width|
	localparam int DVD_W = 34;
	localparam int DVS_W = 17;

	localparam logic [IDX_W-1:0] REG_MEDIA_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] REG_BAND_0      = 3'd1;

	// Band packing
	localparam int UP_MSB  = 47;
	localparam int UP_LSB  = 32;
	localparam int DLO_MSB = 31;
	localparam int DLO_LSB = 16;
	localparam int DHI_MSB = 15;

	typedef struct packed {
		logic signed [CT_W-1:0] ct;
		logic                   found;
		logic [MED_W-1:0]       w;
		logic [BOUND_W-1:0]     lo;
		logic [BOUND_W-1:0]     up;
		logic [DENS_W-1:0]      dlo;
		logic [DENS_W-1:0]      dhi;
		logic [BOUND_W-1:0]     prev;
	} token_t;

endpackage

[rtl/cnmd_ifs.sv]
interface cnmd_in_if;
	import cnmd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [CT_W-1:0] ct_value;
	modport source (output valid, output ct_value, input ready);
	modport sink (input valid, input ct_value, output ready);
endinterface

interface cnmd_out_if;
	import cnmd_pkg::*;
	logic              valid;
	logic              ready;
	logic [MED_W-1:0]  medium_index;
	logic [DENS_W-1:0] density;
	logic              saturated;
	modport source (output valid, output medium_index, output density, output saturated,
		input ready);
	modport sink (input valid, input medium_index, input density, input saturated,
		output ready);
endinterface

interface cnmd_cfg_if;
	import cnmd_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [BAND_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/cnmd_cell.sv]
module cnmd_cell #(
	parameter logic [2:0] INDEX = 3'd0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              band_we,
	input  logic [cnmd_pkg::BAND_W-1:0]       band_data,
	input  logic [cnmd_pkg::MED_W-1:0]        band_cnt,
	input  logic [cnmd_pkg::BOUND_W-1:0]      last_upper,
	input  logic                              tok_v,
	input  cnmd_pkg::token_t                  tok,
	output logic                              tok_v_s1,
	output cnmd_pkg::token_t                  tok_s1,
	output logic [cnmd_pkg::BOUND_W-1:0]      upper
);
	import cnmd_pkg::*;

	logic [BAND_W-1:0] band_q;
	logic              in_use, is_last, match, brk, sel;
	logic signed [CT_W-1:0] prev_s, up_s, last_s;
	token_t            nxt;

	assign upper  = band_q[UP_MSB:UP_LSB];
	assign prev_s = $signed({1'b0, tok.prev});
	assign up_s   = $signed({1'b0, upper});
	assign last_s = $signed({1'b0, last_upper});

	always_comb begin
		in_use  = INDEX < band_cnt;
		is_last = INDEX == band_cnt - 3'd1;
		match   = (tok.ct >= prev_s) && (tok.ct < up_s);
		// negative or beyond the last bound: cell 0 always takes it
		brk     = (tok.ct < 0) || (tok.ct > last_s);
		sel     = !tok.found && in_use && (match || brk || is_last);
		nxt     = tok;
		if (sel) begin
			nxt.found = 1'b1;
			nxt.w     = INDEX;
			nxt.lo    = tok.prev;
			nxt.up    = upper;
			nxt.dlo   = band_q[DLO_MSB:DLO_LSB];
			nxt.dhi   = band_q[DHI_MSB:0];
		end
		if (in_use) begin
			nxt.prev = upper;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q   <= '0;
			tok_v_s1 <= 1'b0;
		end else begin
			if (band_we) begin
				band_q <= band_data;
			end
			tok_v_s1 <= tok_v;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= nxt;
	end

endmodule

[rtl/cnmd_div.sv]
module cnmd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cnmd_pkg::DVD_W-1:0]   dividend,
	input  logic [cnmd_pkg::DVS_W-1:0]   divisor,
	output logic                         busy,
	output logic                         done,
	output logic [cnmd_pkg::DVD_W-1:0]   quotient
);
	import cnmd_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DVS_W:0]   trial, diff;
	logic             ge;

	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

[rtl/ct_number_to_medium_density.sv]
// CT number to medium and density. Each voxel's CT number walks down a row of
// band cells, one cell a cycle; every cell holds one calibration band and the
// first band whose range holds the value (or the last band in use) claims the
// item; a negative value or one beyond the last band's bound goes to the first
// band. A 17x18 multiply then forms (dhi - dlo) * (ct - lo), and a one bit a
// cycle restoring divider divides by the band width with round half away from
// zero. The divider is skipped for negative CT numbers and zero-width bands.
// One item is in flight at a time; a finished result sits in the output
// register while the next voxel is taken. Configuration writes are accepted
// every cycle and must only arrive while the block is idle.
module ct_number_to_medium_density #(
	parameter int MEDIA_MAX = 6
) (
	input logic          clk,
	input logic          arst_n,
	cnmd_in_if.sink      in_ch,
	cnmd_out_if.source   out_ch,
	cnmd_cfg_if.sink     cfg_ch
);
	import cnmd_pkg::*;

	localparam logic [MED_W-1:0] MAX_CNT = MED_W'(MEDIA_MAX);

	typedef enum logic [2:0] {S_IDLE, S_CHAIN, S_MUL, S_PREP, S_DIV, S_FIN} state_t;

	state_t state_q;

	logic [MED_W-1:0]   media_count_q, band_cnt;
	logic [BOUND_W-1:0] last_upper;
	logic [BOUND_W-1:0] uppers [MEDIA_MAX];
	logic               tok_v [MEDIA_MAX+1];
	token_t             tok [MEDIA_MAX+1];
	logic               cfg_fire, in_fire;

	token_t                   item_q;
	logic signed [34:0]       num_q;
	logic signed [BOUND_W:0]  width_q;
	logic [DVD_W-1:0]         dividend;
	logic [DVS_W-1:0]         divisor;
	logic [33:0]              an;
	logic [BOUND_W-1:0]       ad;
	logic                     neg_q, bypass;
	logic                     div_start, div_busy, div_done;
	logic [DVD_W-1:0]         quo;
	logic signed [DVD_W+1:0]  dens_full;
	logic [DENS_W-1:0]        dens_q;
	logic                     sat_q;
	logic signed [BOUND_W:0]  diff_d;
	logic signed [CT_W:0]     diff_ct;

	logic              out_v_q;
	logic [MED_W-1:0]  out_med_q;
	logic [DENS_W-1:0] out_dens_q;
	logic              out_sat_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
	assign in_ch.ready  = state_q == S_IDLE;
	assign in_fire      = in_ch.valid && in_ch.ready;

	assign out_ch.valid        = out_v_q;
	assign out_ch.medium_index = out_med_q;
	assign out_ch.density      = out_dens_q;
	assign out_ch.saturated    = out_sat_q;

	// clamp the band count to 1..MEDIA_MAX
	always_comb begin
		if (media_count_q == '0) begin
			band_cnt = MED_W'(1);
		end else if (media_count_q > MAX_CNT) begin
			band_cnt = MAX_CNT;
		end else begin
			band_cnt = media_count_q;
		end
	end

	always_comb begin
		last_upper = '0;
		for (int i = 0; i < MEDIA_MAX; i++) begin
			if (MED_W'(i) == band_cnt - 3'd1) begin
				last_upper = uppers[i];
			end
		end
	end

	// head of the chain: a fresh item with nothing found yet
	always_comb begin
		tok[0]       = '0;
		tok[0].ct    = in_ch.ct_value;
		tok_v[0]     = in_fire;
	end

	for (genvar g = 0; g < MEDIA_MAX; g++) begin : g_cell
		cnmd_cell #(.INDEX(3'(g))) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.band_we    (cfg_fire && cfg_ch.index == IDX_W'(REG_BAND_0 + 3'(g))),
			.band_data  (cfg_ch.data),
			.band_cnt   (band_cnt),
			.last_upper (last_upper),
			.tok_v      (tok_v[g]),
			.tok        (tok[g]),
			.tok_v_s1   (tok_v[g+1]),
			.tok_s1     (tok[g+1]),
			.upper      (uppers[g])
		);
	end

	// factors of the product for the chosen band
	assign diff_d  = $signed({1'b0, item_q.dhi}) - $signed({1'b0, item_q.dlo});
	assign diff_ct = $signed({item_q.ct[CT_W-1], item_q.ct}) - $signed({2'b0, item_q.lo});

	// magnitudes, and the rounding offset folded into the dividend
	assign an       = num_q < 0 ? 34'(-num_q) : num_q[33:0];
	assign ad       = width_q < 0 ? BOUND_W'(-width_q) : width_q[BOUND_W-1:0];
	assign dividend = {an[32:0], 1'b0} + DVD_W'(ad);
	assign divisor  = {ad, 1'b0};
	assign bypass   = item_q.ct < 0 || width_q == '0;
	assign div_start = state_q == S_PREP && !bypass;

	cnmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	assign dens_full = neg_q ? $signed({2'b0, item_q.dlo}) - $signed({2'b0, quo})
	                         : $signed({2'b0, item_q.dlo}) + $signed({2'b0, quo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			media_count_q <= MED_W'(1);
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_fire && cfg_ch.index == REG_MEDIA_COUNT) begin
				media_count_q <= cfg_ch.data[MED_W-1:0];
			end
			// load a finished result, or drop the one just taken
			if (state_q == S_FIN && (!out_v_q || out_ch.ready)) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (tok_v[MEDIA_MAX]) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= bypass ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hand over once the output register is free
					if (!out_v_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHAIN && tok_v[MEDIA_MAX]) begin
			item_q <= tok[MEDIA_MAX];
		end
		if (state_q == S_MUL) begin
			num_q   <= 35'(diff_d * diff_ct);
			width_q <= $signed({1'b0, item_q.up}) - $signed({1'b0, item_q.lo});
		end
		if (state_q == S_PREP) begin
			neg_q  <= (num_q < 0) != (width_q < 0);
			dens_q <= item_q.dlo;
			sat_q  <= 1'b0;
		end
		if (state_q == S_DIV && div_done) begin
			if (dens_full < 0) begin
				dens_q <= '0;
				sat_q  <= 1'b1;
			end else if (dens_full > $signed({2'b0, {DVD_W-DENS_W{1'b0}}, {DENS_W{1'b1}}})) begin
				dens_q <= '1;
				sat_q  <= 1'b1;
			end else begin
				dens_q <= dens_full[DENS_W-1:0];
				sat_q  <= 1'b0;
			end
		end
		if (state_q == S_FIN && (!out_v_q || out_ch.ready)) begin
			out_med_q  <= item_q.w;
			out_dens_q <= dens_q;
			out_sat_q  <= sat_q;
		end
	end

	// a result never names a band beyond those in use
	a_med_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.medium_index < band_cnt)
		else $error("medium index beyond bands in use");

	// clamping only ever lands on the ends of the range
	a_sat_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.saturated |-> out_ch.density == '0 || out_ch.density == '1)
		else $error("saturated density not at a limit");

	// the divider is quiet whenever a new voxel may be taken
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !div_busy)
		else $error("divider busy while idle");

	// after a transfer in, the next voxel waits until this one is done
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("second voxel taken while one in flight");

endmodule

[tb/ct_number_to_medium_density_test.sv]
module ct_number_to_medium_density_test;
	import cnmd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	// Drain time after the queues empty; covers an item that runs the divider, with margin.
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [MED_W-1:0]  med;
		logic [DENS_W-1:0] dens;
		logic              sat;
	} density_res_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [BAND_W-1:0] data;
	} cfg_word_t;

	logic clk;
	logic arst_n;

	cnmd_in_if  in_ch ();
	cnmd_out_if out_ch ();
	cnmd_cfg_if cfg_ch ();

	ct_number_to_medium_density i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	// Predictor's own copy of the calibration registers
	logic [2:0]        cal_count;
	logic [BAND_W-1:0] cal_band [6];

	logic signed [CT_W-1:0] voxel_queue [$];
	density_res_t           density_due [$];
	cfg_word_t              cal_queue [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  mismatches;
	int  idle_cycles;
	bit  timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic density_res_t predict_density(logic signed [CT_W-1:0] ct_in);
		density_res_t r;
		longint ct, lo, last, width, dlo, dhi, num, an, ad, q, dens;
		int n, w;
		bit neg;
		ct = ct_in;
		n = cal_count;
		if (n < 1) n = 1;
		if (n > 6) n = 6;
		last = cal_band[n-1][UP_MSB:UP_LSB];
		lo = 0;
		for (w = 0; w < n; w++) begin
			if ((ct >= lo && ct < longint'(cal_band[w][UP_MSB:UP_LSB])) || ct < 0 || ct > last)
				break;
			lo = cal_band[w][UP_MSB:UP_LSB];
		end
		if (w >= n) begin
			w = n - 1;
			lo = (w == 0) ? 0 : longint'(cal_band[w-1][UP_MSB:UP_LSB]);
		end
		r.sat = 1'b0;
		if (ct < 0) begin
			w = 0;
			dens = cal_band[0][DLO_MSB:DLO_LSB];
		end else begin
			width = longint'(cal_band[w][UP_MSB:UP_LSB]) - lo;
			dlo = cal_band[w][DLO_MSB:DLO_LSB];
			dhi = cal_band[w][DHI_MSB:0];
			if (width == 0) begin
				dens = dlo;
			end else begin
				num = (dhi - dlo) * (ct - lo);
				neg = (num < 0) != (width < 0);
				an = num < 0 ? -num : num;
				ad = width < 0 ? -width : width;
				// round half away from zero on magnitudes
				q = (an * 2 + ad) / (ad * 2);
				dens = dlo + (neg ? -q : q);
			end
			if (dens < 0) begin
				dens = 0;
				r.sat = 1'b1;
			end else if (dens > 65535) begin
				dens = 65535;
				r.sat = 1'b1;
			end
		end
		r.med = w[MED_W-1:0];
		r.dens = dens[DENS_W-1:0];
		return r;
	endfunction

	// Driver: voxel stream and register writes, both advanced at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.ct_value <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= '0;
			cfg_ch.data <= '0;
		end else begin
			// Drop the transfer that just completed, then offer the next one
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cal_queue.size() > 0) begin
					cfg_ch.index <= cal_queue[0].idx;
					cfg_ch.data <= cal_queue[0].data;
					void'(cal_queue.pop_front());
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end else if (!cfg_ch.valid && cal_queue.size() > 0) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= cal_queue[0].idx;
				cfg_ch.data <= cal_queue[0].data;
				void'(cal_queue.pop_front());
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (voxel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.ct_value <= voxel_queue.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		density_res_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_MEDIA_COUNT)
					cal_count <= cfg_ch.data[2:0];
				else if (cfg_ch.index >= REG_BAND_0 && cfg_ch.index <= REG_BAND_0 + 5)
					cal_band[cfg_ch.index - REG_BAND_0] <= cfg_ch.data;
			end
			if (in_ch.valid && in_ch.ready)
				density_due.push_back(predict_density(in_ch.ct_value));
			if (out_ch.valid && out_ch.ready) begin
				got.med = out_ch.medium_index;
				got.dens = out_ch.density;
				got.sat = out_ch.saturated;
				if (density_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: medium %0d density %0d sat %0d",
							got.med, got.dens, got.sat);
				end else begin
					want = density_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp medium %0d dens %0d sat %0d, got %0d %0d %0d",
								want.med, want.dens, want.sat,
								got.med, got.dens, got.sat);
					end
				end
			end
		end
	end

	// Watchdog: count cycles in which nothing transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
				timed_out = 1'b1;
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic queue_write(logic [IDX_W-1:0] idx, logic [BAND_W-1:0] data);
		cfg_word_t c;
		c.idx = idx;
		c.data = data;
		cal_queue.push_back(c);
	endtask

	function automatic logic [BAND_W-1:0] pack_band(int up, int dlo, int dhi);
		return {up[15:0], dlo[15:0], dhi[15:0]};
	endfunction

	// Wait for every result and give the block time to fall idle
	task automatic wait_quiet();
		while (voxel_queue.size() > 0 || in_ch.valid || density_due.size() > 0
				|| cal_queue.size() > 0 || cfg_ch.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Calibration for one phase: random, increasing, or edge-case tables
	task automatic load_calibration(int kind);
		int n, b, up;
		n = (kind == 0) ? 6 : (kind == 1) ? 1 : $urandom_range(7);
		queue_write(REG_MEDIA_COUNT, BAND_W'(n));
		up = 0;
		for (b = 0; b < 6; b++) begin
			case (kind)
				0: up = (b == 5) ? 16'hFFFF : up + $urandom_range(1, 12000);
				1: up = 16'hFFFF;
				3: up = $urandom_range(65535);
				default: up = ($urandom_range(5) == 0) ? up : up + $urandom_range(0, 3000);
			endcase
			queue_write(IDX_W'(REG_BAND_0 + b), pack_band(up,
				(kind == 1) ? 16'hFFFF : $urandom_range(65535),
				(kind == 1) ? 16'h0000 : $urandom_range(65535)));
		end
	endtask

	// Mostly non-negative values within the table, with some negatives and extremes
	task automatic queue_random_voxels(int count);
		int k, r, span;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(9);
			span = cal_band[5][UP_MSB:UP_LSB];
			if (r == 0)
				voxel_queue.push_back(CT_W'(-int'($urandom_range(1, 65536))));
			else if (r == 1)
				voxel_queue.push_back(CT_W'($urandom_range(65535)));
			else
				voxel_queue.push_back(CT_W'($urandom_range(span > 0 ? span + 1 : 65535)));
		end
	endtask

	initial begin
		int ph;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 74;
		cal_count = 3'd1;
		foreach (cal_band[b]) cal_band[b] = '0;
		in_ch.valid = 1'b0;
		in_ch.ct_value = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset table, then an edge-case table with zero-width bands
		voxel_queue.push_back(17'sd0);
		voxel_queue.push_back(17'sd65535);
		voxel_queue.push_back(17'sh10000);
		wait_quiet();
		queue_write(REG_MEDIA_COUNT, BAND_W'(4));
		queue_write(REG_BAND_0,             pack_band(100, 1000, 5000));
		queue_write(IDX_W'(REG_BAND_0 + 1), pack_band(100, 7000, 9000));   // zero width
		queue_write(IDX_W'(REG_BAND_0 + 2), pack_band(300, 0, 65535));
		queue_write(IDX_W'(REG_BAND_0 + 3), pack_band(50, 20000, 100));    // bound goes down
		queue_write(IDX_W'(REG_BAND_0 + 4), pack_band(65535, 65535, 0));
		queue_write(IDX_W'(REG_BAND_0 + 5), pack_band(1, 1, 1));
		wait_quiet();
		voxel_queue = '{0, 1, 99, 100, 101, 299, 300, 49, 50, 51, 65535, -1, -65536,
			17'sh0AAAA, 17'sh15555};
		wait_quiet();
		// Extremes: count beyond six, count zero, bands saturating both ways
		queue_write(REG_MEDIA_COUNT, BAND_W'(7));
		queue_write(REG_BAND_0, pack_band(10, 0, 65535));
		wait_quiet();
		voxel_queue = '{0, 5, 9, 10, 11, 40000, 65535};
		wait_quiet();
		queue_write(REG_MEDIA_COUNT, BAND_W'(0));
		queue_write(REG_BAND_0, pack_band(10, 65535, 0));
		wait_quiet();
		voxel_queue = '{3, 10, 11, 65535, -5};
		wait_quiet();

		// Random phases: receiver-heavy idling, then sender-heavy, then none
		for (ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 74;
				recv_idle_pct = 35;
			end else if (ph == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_calibration(ph % 4);
			wait_quiet();
			queue_random_voxels(140);
			wait_quiet();
		end

		if (mismatches == 0 && density_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
